>>> hdl/deq_pkg.sv
// Shared constants, codes and types of the double-ended queue.
package deq_pkg;

  localparam int DEPTH   = 32;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SHOW       = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SHOW = 1'b1
  } ctrl_state_t;

  // One command to the whole row of cells; at most one bit is set.
  typedef struct packed {
    logic shift_in;   // push front: every cell takes its left neighbour
    logic append;     // push back: first empty cell takes the pushed value
    logic shift_out;  // pop front: every cell takes its right neighbour
    logic drop_back;  // pop back: the back cell is invalidated
    logic rotate;     // show: front moves to the back, the rest move forward
  } cell_cmd_t;

endpackage

>>> hdl/deq_in_if.sv
// Input channel of the queue: opcode and value under valid/ready.
interface deq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           opcode;
  logic signed [deq_pkg::VALUE_W-1:0]   value;

  modport source (output valid, opcode, value, input ready);
  modport sink   (input valid, opcode, value, output ready);
endinterface

>>> hdl/deq_out_if.sv
// Result channel of the queue: value, status and last under valid/ready.
interface deq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [deq_pkg::VALUE_W-1:0]   value_out;
  logic [1:0]                           status;
  logic                                 last;

  modport source (output valid, value_out, status, last, input ready);
  modport sink   (input valid, value_out, status, last, output ready);
endinterface

>>> hdl/deq_cell.sv
// One storage cell of the queue row, exchanging data with its two neighbours.
module deq_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  deq_pkg::cell_cmd_t                 cmd,
  input  logic signed [deq_pkg::VALUE_W-1:0] left_data,
  input  logic                               left_valid,
  input  logic signed [deq_pkg::VALUE_W-1:0] right_data,
  input  logic                               right_valid,
  input  logic signed [deq_pkg::VALUE_W-1:0] head_data,
  input  logic signed [deq_pkg::VALUE_W-1:0] push_data,
  output logic signed [deq_pkg::VALUE_W-1:0] data_o,
  output logic                               valid_o,
  output logic signed [deq_pkg::VALUE_W-1:0] back_data_o
);

  logic signed [deq_pkg::VALUE_W-1:0] data_r, data_nxt;
  logic                               valid_r, valid_nxt;
  logic                               is_back;

  assign is_back = valid_r && !right_valid;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (cmd.shift_in) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (cmd.append) begin
      if (!valid_r && left_valid) begin
        data_nxt  = push_data;
        valid_nxt = 1'b1;
      end
    end else if (cmd.shift_out) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (cmd.drop_back) begin
      valid_nxt = valid_r && right_valid;
    end else if (cmd.rotate) begin
      // The back cell closes the ring by taking the old front entry.
      if (valid_r) begin
        data_nxt = is_back ? head_data : right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o      = data_r;
  assign valid_o     = valid_r;
  assign back_data_o = is_back ? data_r : '0;

endmodule

>>> hdl/deq_ctrl.sv
// Sequencer of the queue: decodes items, commands the cells, holds the result.
module deq_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  deq_in_if.sink                             in_if,
  deq_out_if.source                          out_if,
  input  logic signed [deq_pkg::VALUE_W-1:0] head_data,
  input  logic signed [deq_pkg::VALUE_W-1:0] back_data,
  output deq_pkg::cell_cmd_t                 cmd
);

  deq_pkg::ctrl_state_t               state_r, state_nxt;
  logic [deq_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic [deq_pkg::CNT_W-1:0]          rem_r, rem_nxt;
  logic                               out_valid_r;
  logic signed [deq_pkg::VALUE_W-1:0] out_value_r, res_value;
  deq_pkg::status_t                   out_status_r, res_status;
  logic                               out_last_r, res_last;
  logic                               res_load;
  logic                               slot_free;
  logic                               acc;
  logic                               full;
  logic                               empty;

  assign slot_free   = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == deq_pkg::S_IDLE) && slot_free;
  assign acc         = in_if.valid && in_if.ready;
  assign full        = (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty       = (count_r == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      deq_pkg::S_IDLE: begin
        if (acc && in_if.opcode == deq_pkg::OP_SHOW && !empty) begin
          state_nxt = deq_pkg::S_SHOW;
        end
      end
      deq_pkg::S_SHOW: begin
        if (slot_free && rem_r == deq_pkg::CNT_W'(1)) begin
          state_nxt = deq_pkg::S_IDLE;
        end
      end
      default: state_nxt = deq_pkg::S_IDLE;
    endcase
  end

  // Cell commands, result and counters.
  always_comb begin
    cmd        = '0;
    res_load   = 1'b0;
    res_value  = '0;
    res_status = deq_pkg::ST_OK;
    res_last   = 1'b1;
    count_nxt  = count_r;
    rem_nxt    = rem_r;
    case (state_r)
      deq_pkg::S_IDLE: begin
        if (acc) begin
          case (in_if.opcode)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
              res_load = 1'b1;
              if (full) begin
                res_status = deq_pkg::ST_FULL;
              end else begin
                cmd.shift_in = (in_if.opcode == deq_pkg::OP_PUSH_FRONT);
                cmd.append   = (in_if.opcode == deq_pkg::OP_PUSH_BACK);
                count_nxt    = count_r + deq_pkg::CNT_W'(1);
              end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
              res_load = 1'b1;
              if (empty) begin
                res_status = deq_pkg::ST_EMPTY;
              end else if (in_if.opcode == deq_pkg::OP_POP_FRONT) begin
                cmd.shift_out = 1'b1;
                res_value     = head_data;
                count_nxt     = count_r - deq_pkg::CNT_W'(1);
              end else begin
                cmd.drop_back = 1'b1;
                res_value     = back_data;
                count_nxt     = count_r - deq_pkg::CNT_W'(1);
              end
            end
            deq_pkg::OP_SHOW: begin
              if (empty) begin
                res_load   = 1'b1;
                res_status = deq_pkg::ST_EMPTY;
              end else begin
                rem_nxt = count_r;
              end
            end
            default: ;
          endcase
        end
      end
      deq_pkg::S_SHOW: begin
        // Each transfer lists the front entry and turns the ring by one, so
        // after count steps the entries stand in their original order.
        if (slot_free) begin
          cmd.rotate = 1'b1;
          res_load   = 1'b1;
          res_value  = head_data;
          res_last   = (rem_r == deq_pkg::CNT_W'(1));
          rem_nxt    = rem_r - deq_pkg::CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deq_pkg::S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
      out_last_r   <= res_last;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.value_out = out_value_r;
  assign out_if.status    = out_status_r;
  assign out_if.last      = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("queue count exceeds its depth");

  a_show_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == deq_pkg::S_SHOW |-> (rem_r != '0 && rem_r <= count_r && !in_if.ready))
    else $error("listing in progress with a bad remaining count or input open");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    acc && full && (in_if.opcode == deq_pkg::OP_PUSH_FRONT ||
                    in_if.opcode == deq_pkg::OP_PUSH_BACK)
    |=> $stable(count_r) && out_if.status == deq_pkg::ST_FULL)
    else $error("push into a full queue changed the count or was not flagged");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !empty && (in_if.opcode == deq_pkg::OP_POP_FRONT ||
                      in_if.opcode == deq_pkg::OP_POP_BACK)
    |=> count_r == $past(count_r) - deq_pkg::CNT_W'(1))
    else $error("pop did not remove exactly one entry");

endmodule

>>> hdl/double_ended_queue.sv
// Top level of the double-ended queue: a row of cells and its sequencer.
//
//   channel  direction  transfer contents
//   in_if    sink       opcode (3 bits), value (signed 32 bits)
//   out_if   source     value_out (signed 32 bits), status (2 bits), last
//
// On a push or pop the item is accepted, the row of cells is updated at that
// edge and the single result is registered for transfer.
// Show lists the entries one per result transfer, as the row turns by one
// cell per result transfer; no input is accepted meanwhile.
// Reset (rst_n low, synchronous) empties the queue; cell data are not cleared.
// A stalled result holds the input off until it is taken.
module double_ended_queue (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_if,
  deq_out_if.source out_if
);

  deq_pkg::cell_cmd_t                 cmd;
  logic signed [deq_pkg::VALUE_W-1:0] cell_data [deq_pkg::DEPTH];
  logic                               cell_valid [deq_pkg::DEPTH];
  logic signed [deq_pkg::VALUE_W-1:0] cell_back [deq_pkg::DEPTH];
  logic signed [deq_pkg::VALUE_W-1:0] back_data;

  for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
    logic signed [deq_pkg::VALUE_W-1:0] left_data, right_data;
    logic                               left_valid, right_valid;

    // The front cell sees the pushed value as an always valid left neighbour.
    if (i == 0) begin : g_front
      assign left_data  = in_if.value;
      assign left_valid = 1'b1;
    end else begin : g_inner
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == deq_pkg::DEPTH - 1) begin : g_end
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    deq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .right_data  (right_data),
      .right_valid (right_valid),
      .head_data   (cell_data[0]),
      .push_data   (in_if.value),
      .data_o      (cell_data[i]),
      .valid_o     (cell_valid[i]),
      .back_data_o (cell_back[i])
    );
  end

  // Only the back cell offers non-zero data, so an OR picks it out.
  always_comb begin
    back_data = '0;
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      back_data = back_data | cell_back[i];
    end
  end

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .head_data (cell_data[0]),
    .back_data (back_data),
    .cmd       (cmd)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench of the double-ended queue, with a mirror of its contents.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD   = 150;
  localparam int RAND_ITEMS  = 240;
  localparam int SETTLE_CYC  = 40;
  localparam int MAX_GAP     = 13;

  // Mirror of the queue: it applies each accepted command and holds the
  // results that the block owes, oldest first.
  class deq_mirror;
    typedef struct {
      logic signed [deq_pkg::VALUE_W-1:0] value;
      deq_pkg::status_t                   status;
      logic                               last;
    } result_t;

    logic signed [deq_pkg::VALUE_W-1:0] slots [deq_pkg::DEPTH];
    int unsigned                        head;
    int unsigned                        fill;
    result_t                            owed[$];
    int unsigned                        errors;

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
    endfunction

    function void owe(logic signed [deq_pkg::VALUE_W-1:0] v, deq_pkg::status_t st,
                      logic lst);
      result_t r;
      r.value  = v;
      r.status = st;
      r.last   = lst;
      owed.push_back(r);
    endfunction

    function void apply_command(logic [2:0] op, logic signed [deq_pkg::VALUE_W-1:0] val);
      case (op)
        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
          if (fill >= deq_pkg::DEPTH) begin
            owe('0, deq_pkg::ST_FULL, 1'b1);
          end else begin
            if (op == deq_pkg::OP_PUSH_FRONT) begin
              head = (head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
              slots[head] = val;
            end else begin
              slots[(head + fill) % deq_pkg::DEPTH] = val;
            end
            fill++;
            owe('0, deq_pkg::ST_OK, 1'b1);
          end
        end
        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
          if (fill == 0) begin
            owe('0, deq_pkg::ST_EMPTY, 1'b1);
          end else if (op == deq_pkg::OP_POP_FRONT) begin
            owe(slots[head], deq_pkg::ST_OK, 1'b1);
            head = (head + 1) % deq_pkg::DEPTH;
            fill--;
          end else begin
            owe(slots[(head + fill - 1) % deq_pkg::DEPTH], deq_pkg::ST_OK, 1'b1);
            fill--;
          end
        end
        deq_pkg::OP_SHOW: begin
          if (fill == 0) begin
            owe('0, deq_pkg::ST_EMPTY, 1'b1);
          end else begin
            for (int unsigned i = 0; i < fill; i++)
              owe(slots[(head + i) % deq_pkg::DEPTH], deq_pkg::ST_OK, (i + 1 == fill));
          end
        end
        default: begin
          // Undefined opcodes leave the queue alone and give nothing back.
        end
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic signed [deq_pkg::VALUE_W-1:0] v, logic [1:0] st, logic lst);
      result_t e;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result value %0d status %0d last %0b", v, st, lst));
        return;
      end
      e = owed.pop_front();
      if (v !== e.value)
        report($sformatf("value_out %0d, expected %0d", v, e.value));
      if (st !== e.status)
        report($sformatf("status %0d, expected %0d", st, e.status));
      if (lst !== e.last)
        report($sformatf("last %0b, expected %0b", lst, e.last));
    endtask
  endclass

  logic clk;
  logic rst_n;

  deq_in_if  in_if();
  deq_out_if out_if();

  double_ended_queue u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  deq_mirror   mirror = new();
  bit          gaps_on;
  bit          hold_go;
  int unsigned cmds_taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, MAX_GAP) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      mirror.check_result(out_if.value_out, out_if.status, out_if.last);
  end

  function automatic logic signed [deq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Starts and ends at a falling edge; valid stays high into the next call.
  task automatic send_cmd(input logic [2:0] op,
                          input logic signed [deq_pkg::VALUE_W-1:0] val);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.value  <= val;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    mirror.apply_command(op, val);
    if (op <= deq_pkg::OP_SHOW)
      cmds_taken++;
    @(negedge clk);
  endtask

  // Always moves on to a later falling edge, so valid is driven once
  // in each time step.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (mirror.owed.size() != 0);
  endtask

  task automatic push_any();
    send_cmd($urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
             pick_value());
  endtask

  task automatic pop_any();
    send_cmd($urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK,
             $urandom);
  endtask

  task automatic fill_up();
    while (mirror.fill < deq_pkg::DEPTH)
      push_any();
    repeat ($urandom_range(1, 3)) push_any();
    send_cmd(deq_pkg::OP_SHOW, $urandom);
  endtask

  task automatic empty_out();
    while (mirror.fill > 0) begin
      if ($urandom_range(0, 7) == 0)
        send_cmd(deq_pkg::OP_SHOW, $urandom);
      pop_any();
    end
    repeat ($urandom_range(1, 2)) pop_any();
    send_cmd(deq_pkg::OP_SHOW, $urandom);
  endtask

  task automatic mixed_run(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 25)      send_cmd(deq_pkg::OP_PUSH_FRONT, pick_value());
      else if (r < 50) send_cmd(deq_pkg::OP_PUSH_BACK, pick_value());
      else if (r < 65) send_cmd(deq_pkg::OP_POP_FRONT, $urandom);
      else if (r < 80) send_cmd(deq_pkg::OP_POP_BACK, $urandom);
      else if (r < 92) send_cmd(deq_pkg::OP_SHOW, $urandom);
      else             send_cmd(3'($urandom_range(5, 7)), $urandom);
    end
  endtask

  initial begin
    int unsigned goal;
    int          seg;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.opcode = '0;
    in_if.value  = '0;
    gaps_on      = 1'b0;
    hold_go      = 1'b0;
    cmds_taken   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty queue answers, extremes at both ends, ignored opcodes.
    send_cmd(deq_pkg::OP_POP_FRONT, 32'h7FFF_FFFF);
    send_cmd(deq_pkg::OP_POP_BACK, 32'h8000_0000);
    send_cmd(deq_pkg::OP_SHOW, '1);
    send_cmd(deq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_cmd(deq_pkg::OP_PUSH_BACK, 32'h8000_0000);
    send_cmd(deq_pkg::OP_PUSH_FRONT, '0);
    send_cmd(deq_pkg::OP_PUSH_BACK, '1);
    send_cmd(deq_pkg::OP_PUSH_FRONT, 32'sd1);
    send_cmd(deq_pkg::OP_SHOW, '0);
    send_cmd(3'd5, 32'h5555_5555);
    send_cmd(3'd6, 32'hAAAA_AAAA);
    send_cmd(3'd7, '1);
    send_cmd(deq_pkg::OP_POP_FRONT, '0);
    send_cmd(deq_pkg::OP_POP_BACK, '0);
    send_cmd(deq_pkg::OP_SHOW, '0);
    send_cmd(deq_pkg::OP_POP_FRONT, '0);
    send_cmd(deq_pkg::OP_POP_BACK, '0);
    send_cmd(deq_pkg::OP_POP_FRONT, '0);
    send_cmd(deq_pkg::OP_POP_BACK, '0);
    send_cmd(deq_pkg::OP_SHOW, '0);
    send_cmd(deq_pkg::OP_PUSH_BACK, 32'h5555_5555);
    send_cmd(deq_pkg::OP_PUSH_FRONT, 32'hAAAA_AAAA);
    send_cmd(deq_pkg::OP_POP_BACK, '0);
    send_cmd(deq_pkg::OP_POP_BACK, '0);
    wait_drained();

    // The receiver holds off while the sender keeps offering pushes, so the
    // block must stall its input until the results start to move again.
    goal = cmds_taken + RAND_ITEMS;
    gaps_on = 1'b1;
    hold_go = 1'b1;
    fill_up();
    wait_drained();

    seg = 0;
    while (cmds_taken < goal) begin
      gaps_on = (goal - cmds_taken > 50) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       fill_up();
        1:       empty_out();
        default: mixed_run($urandom_range(10, 30));
      endcase
      seg++;
      if (seg % 3 == 0)
        wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mirror.errors == 0 && mirror.owed.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
